// ===== hdl/lecm_pkg.sv =====
// ----------------------------------------------------------------------------
// lecm_pkg
// Shared types and constants for the console line editor and command matcher:
// character codes, the command table, and the item bundle passed between the
// edit stage and the result sequencer.
// ----------------------------------------------------------------------------
package lecm_pkg;

	// Character codes
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TILDE = 8'd126;
	localparam logic [7:0] CH_DEL   = 8'd127;

	// Full LED intensity
	localparam logic [7:0] LED_FULL = 8'd255;

	// Bundle operation codes
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_CHAR  = 2'd1;
	localparam logic [1:0] OP_ERASE = 2'd2;
	localparam logic [1:0] OP_LINE  = 2'd3;

	// Result beat indexes within one item
	localparam logic [1:0] BEAT_FIRST  = 2'd0;
	localparam logic [1:0] BEAT_SECOND = 2'd1;
	localparam logic [1:0] BEAT_THIRD  = 2'd2;

	// Command table: text padded to CMD_SLOTS bytes, length, color
	localparam int NUM_CMDS  = 5;
	localparam int CMD_SLOTS = 8;
	localparam int MM_W      = 3;

	localparam logic [7:0] CMD_TEXT [NUM_CMDS][CMD_SLOTS] = '{
		'{"L", "E", "D", "_", "O", "N", 8'h00, 8'h00},
		'{"L", "E", "D", "_", "O", "F", "F", 8'h00},
		'{"R", "E", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"G", "R", "E", "E", "N", 8'h00, 8'h00, 8'h00},
		'{"B", "L", "U", "E", 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [MM_W-1:0] CMD_LEN [NUM_CMDS] = '{
		3'd6, 3'd7, 3'd3, 3'd5, 3'd4
	};

	localparam logic [7:0] LVL_RED   [NUM_CMDS] = '{LED_FULL, 8'd0, LED_FULL, 8'd0, 8'd0};
	localparam logic [7:0] LVL_GREEN [NUM_CMDS] = '{LED_FULL, 8'd0, 8'd0, LED_FULL, 8'd0};
	localparam logic [7:0] LVL_BLUE  [NUM_CMDS] = '{LED_FULL, 8'd0, 8'd0, 8'd0, LED_FULL};

	// What one item asks of the result sequencer
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
		logic       led_write;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       unknown;
	} bundle_t;

endpackage

// ===== hdl/line_editor_command_matcher.sv =====
// ----------------------------------------------------------------------------
// line_editor_command_matcher
// Console line editor with a fixed command matcher for an LED.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on item_valid/item_ready: kind 1 clears the line, kind 0
//   carries a received byte in rx_byte. Results leave on
//   result_valid/result_ready: echo characters, then on a completed line
//   an LED color write or the unknown_command flag; last marks the final
//   result of an item.
//   An accepted item waits in the input register until its bundle loads
//   the result register, which happens once that register is free; the
//   first result then stands on the outputs.
//   A printable byte gives one result, so while the receiver takes every
//   result items flow at one per cycle; erase and line end give three
//   results, one per cycle from the result register while result_ready holds.
//   Items that give no result pass without touching the result register.
//   While the receiver stalls, the current result holds and the input
//   register keeps one more item, after which item_ready drops.
//   Reset clears the line and empties both registers.
// ----------------------------------------------------------------------------
module line_editor_command_matcher #(
	parameter int LINE_CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic       kind,
	input  logic [7:0] rx_byte,
	output logic       result_valid,
	input  logic       result_ready,
	output logic       is_echo,
	output logic [7:0] echo_byte,
	output logic       led_write,
	output logic [7:0] led_red,
	output logic [7:0] led_green,
	output logic [7:0] led_blue,
	output logic       unknown_command,
	output logic       last
);

	logic              valid_s1;
	logic              kind_s1;
	logic [7:0]        rx_byte_s1;
	logic              advance;
	logic              free;
	lecm_pkg::bundle_t bundle;

	// Move the item on when it needs no result slot or the slot frees up
	assign advance    = valid_s1 && ((bundle.op == lecm_pkg::OP_NONE) || free);
	assign item_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			kind_s1    <= kind;
			rx_byte_s1 <= rx_byte;
		end
	end

	lecm_edit #(
		.LINE_CAPACITY (LINE_CAPACITY)
	) u_edit (
		.clk        (clk),
		.arst_n     (arst_n),
		.kind_s1    (kind_s1),
		.rx_byte_s1 (rx_byte_s1),
		.advance    (advance),
		.bundle     (bundle)
	);

	lecm_emit u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (advance && (bundle.op != lecm_pkg::OP_NONE)),
		.bundle          (bundle),
		.free            (free),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.is_echo         (is_echo),
		.echo_byte       (echo_byte),
		.led_write       (led_write),
		.led_red         (led_red),
		.led_green       (led_green),
		.led_blue        (led_blue),
		.unknown_command (unknown_command),
		.last            (last)
	);

endmodule

// ===== hdl/lecm_edit.sv =====
// ----------------------------------------------------------------------------
// lecm_edit
// Line state and item decode. Tracks the line length and, for each command,
// how many leading characters of the line still agree with it, so that a
// line end resolves the match without reading back the stored text.
// ----------------------------------------------------------------------------
module lecm_edit #(
	parameter int LINE_CAPACITY = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 kind_s1,
	input  logic [7:0]           rx_byte_s1,
	input  logic                 advance,
	output lecm_pkg::bundle_t    bundle
);

	localparam int LW = $clog2(LINE_CAPACITY);
	localparam logic [LW-1:0] LEN_FULL = LW'(LINE_CAPACITY - 1);

	logic [LW-1:0]             len_q;
	logic [LW-1:0]             len_d;
	logic [lecm_pkg::MM_W-1:0] mm_q [lecm_pkg::NUM_CMDS];
	logic [lecm_pkg::MM_W-1:0] mm_d [lecm_pkg::NUM_CMDS];

	// Decode the item, derive next line state and the result bundle
	always_comb begin
		logic          hit;
		logic [LW-1:0] len_m1;
		len_d  = len_q;
		mm_d   = mm_q;
		bundle = '0;
		bundle.op = lecm_pkg::OP_NONE;
		hit    = 1'b0;
		len_m1 = len_q - LW'(1);
		if (kind_s1) begin
			// receive overflow: drop the line
			len_d = '0;
			for (int i = 0; i < lecm_pkg::NUM_CMDS; i++) begin
				mm_d[i] = '0;
			end
		end else if (rx_byte_s1 inside {lecm_pkg::CH_CR, lecm_pkg::CH_LF}) begin
			if (len_q != '0) begin
				bundle.op = lecm_pkg::OP_LINE;
				// scan from the back so the first table entry wins
				for (int i = lecm_pkg::NUM_CMDS - 1; i >= 0; i--) begin
					if (len_q == LW'(lecm_pkg::CMD_LEN[i]) &&
					    mm_q[i] == lecm_pkg::CMD_LEN[i]) begin
						hit          = 1'b1;
						bundle.red   = lecm_pkg::LVL_RED[i];
						bundle.green = lecm_pkg::LVL_GREEN[i];
						bundle.blue  = lecm_pkg::LVL_BLUE[i];
					end
				end
				bundle.led_write = hit;
				bundle.unknown   = !hit;
				len_d = '0;
				for (int i = 0; i < lecm_pkg::NUM_CMDS; i++) begin
					mm_d[i] = '0;
				end
			end
		end else if (rx_byte_s1 inside {lecm_pkg::CH_BS, lecm_pkg::CH_DEL}) begin
			if (len_q != '0) begin
				bundle.op = lecm_pkg::OP_ERASE;
				len_d     = len_m1;
				// agreement can reach no further than the shortened line
				for (int i = 0; i < lecm_pkg::NUM_CMDS; i++) begin
					if (LW'(mm_q[i]) > len_m1) begin
						mm_d[i] = len_m1[lecm_pkg::MM_W-1:0];
					end
				end
			end
		end else if (rx_byte_s1 inside {[lecm_pkg::CH_SPACE:lecm_pkg::CH_TILDE]}) begin
			if (len_q != LEN_FULL) begin
				bundle.op   = lecm_pkg::OP_CHAR;
				bundle.data = rx_byte_s1;
				len_d       = len_q + LW'(1);
				// extend agreement when the new character continues the command
				for (int i = 0; i < lecm_pkg::NUM_CMDS; i++) begin
					if (LW'(mm_q[i]) == len_q &&
					    len_q < LW'(lecm_pkg::CMD_LEN[i]) &&
					    rx_byte_s1 == lecm_pkg::CMD_TEXT[i][mm_q[i]]) begin
						mm_d[i] = mm_q[i] + lecm_pkg::MM_W'(1);
					end
				end
			end
		end
	end

	// Advance the line state when the item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			for (int i = 0; i < lecm_pkg::NUM_CMDS; i++) begin
				mm_q[i] <= '0;
			end
		end else if (advance) begin
			len_q <= len_d;
			mm_q  <= mm_d;
		end
	end

endmodule

// ===== hdl/lecm_emit.sv =====
// ----------------------------------------------------------------------------
// lecm_emit
// Result register and beat sequencer. Holds one item's bundle and plays out
// its one or three results, the last one flagged.
// ----------------------------------------------------------------------------
module lecm_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  lecm_pkg::bundle_t bundle,
	output logic              free,
	output logic              result_valid,
	input  logic              result_ready,
	output logic              is_echo,
	output logic [7:0]        echo_byte,
	output logic              led_write,
	output logic [7:0]        led_red,
	output logic [7:0]        led_green,
	output logic [7:0]        led_blue,
	output logic              unknown_command,
	output logic              last
);

	lecm_pkg::bundle_t bundle_q;
	logic              valid_q;
	logic [1:0]        beat_q;
	logic              last_beat;
	logic              finish;

	assign last_beat    = (bundle_q.op == lecm_pkg::OP_CHAR) ||
	                      (beat_q == lecm_pkg::BEAT_THIRD);
	assign finish       = valid_q && result_ready && last_beat;
	assign free         = !valid_q || finish;
	assign result_valid = valid_q;
	assign last         = last_beat;

	// Select the fields of the current beat
	always_comb begin
		is_echo         = 1'b0;
		echo_byte       = '0;
		led_write       = 1'b0;
		led_red         = '0;
		led_green       = '0;
		led_blue        = '0;
		unknown_command = 1'b0;
		case (bundle_q.op)
			lecm_pkg::OP_CHAR: begin
				is_echo   = 1'b1;
				echo_byte = bundle_q.data;
			end
			lecm_pkg::OP_ERASE: begin
				is_echo   = 1'b1;
				echo_byte = (beat_q == lecm_pkg::BEAT_SECOND) ? lecm_pkg::CH_SPACE
				                                               : lecm_pkg::CH_BS;
			end
			lecm_pkg::OP_LINE: begin
				case (beat_q)
					lecm_pkg::BEAT_FIRST: begin
						is_echo   = 1'b1;
						echo_byte = lecm_pkg::CH_CR;
					end
					lecm_pkg::BEAT_SECOND: begin
						is_echo   = 1'b1;
						echo_byte = lecm_pkg::CH_LF;
					end
					default: begin
						led_write       = bundle_q.led_write;
						led_red         = bundle_q.red;
						led_green       = bundle_q.green;
						led_blue        = bundle_q.blue;
						unknown_command = bundle_q.unknown;
					end
				endcase
			end
			default: begin
				is_echo = 1'b0;
			end
		endcase
	end

	// Hold the bundle; step beats on each taken result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= lecm_pkg::BEAT_FIRST;
		end else if (load) begin
			valid_q <= 1'b1;
			beat_q  <= lecm_pkg::BEAT_FIRST;
		end else if (finish) begin
			valid_q <= 1'b0;
			beat_q  <= lecm_pkg::BEAT_FIRST;
		end else if (valid_q && result_ready) begin
			beat_q <= beat_q + 2'd1;
		end
	end

	// Payload needs no reset
	always_ff @(posedge clk) begin
		if (load) begin
			bundle_q <= bundle;
		end
	end

endmodule

// ===== hdl/lecm_checker.sv =====
// ----------------------------------------------------------------------------
// lecm_checker
// Port-level checks for the line editor: result handshake and the ordering
// and exclusivity of result kinds.
// ----------------------------------------------------------------------------
module lecm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       result_valid,
	input logic       result_ready,
	input logic       is_echo,
	input logic [7:0] echo_byte,
	input logic       led_write,
	input logic       unknown_command,
	input logic       last
);

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(echo_byte) &&
		$stable(is_echo) && $stable(last))
	else $error("result changed while stalled");

	// Echo, LED write and unknown flag exclude each other
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(is_echo && (led_write || unknown_command)) &&
		!(led_write && unknown_command))
	else $error("result kinds overlap");

	// A command result always ends its item
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_echo |-> last && (led_write || unknown_command))
	else $error("command result not final or empty");

	// CR echo is followed at once by LF echo
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && is_echo && echo_byte == lecm_pkg::CH_CR |=>
		result_valid && is_echo && echo_byte == lecm_pkg::CH_LF && !last)
	else $error("CR not followed by LF");

endmodule

bind line_editor_command_matcher lecm_checker u_lecm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.result_valid    (result_valid),
	.result_ready    (result_ready),
	.is_echo         (is_echo),
	.echo_byte       (echo_byte),
	.led_write       (led_write),
	.unknown_command (unknown_command),
	.last            (last)
);

// ===== bench/line_editor_command_matcher_checker.sv =====
// ----------------------------------------------------------------------------
// line_editor_command_matcher_checker
// Watches both channels of the line editor, keeps its own copy of the edited
// line, predicts the echo and command results of every accepted item and
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module line_editor_command_matcher_checker #(
	parameter int LINE_CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_ready,
	input  logic       kind,
	input  logic [7:0] rx_byte,
	input  logic       result_valid,
	input  logic       result_ready,
	input  logic       is_echo,
	input  logic [7:0] echo_byte,
	input  logic       led_write,
	input  logic [7:0] led_red,
	input  logic [7:0] led_green,
	input  logic [7:0] led_blue,
	input  logic       unknown_command,
	input  logic       last,
	output int         errors,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEN_W = $clog2(LINE_CAPACITY);

	typedef struct packed {
		logic       is_echo;
		logic [7:0] echo_byte;
		logic       led_write;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       unknown;
		logic       last;
	} console_result_t;

	typedef enum int {
		WORD_LED_ON,
		WORD_LED_OFF,
		WORD_RED,
		WORD_GREEN,
		WORD_BLUE,
		WORD_NONE
	} word_t;

	logic [7:0]       line_buf [LINE_CAPACITY-1];
	logic [LEN_W-1:0] line_len;
	console_result_t  console_q [$];

	function automatic string word_text(word_t w);
		case (w)
			WORD_LED_ON:  return "LED_ON";
			WORD_LED_OFF: return "LED_OFF";
			WORD_RED:     return "RED";
			WORD_GREEN:   return "GREEN";
			WORD_BLUE:    return "BLUE";
			default:      return "";
		endcase
	endfunction

	// Find the command that the stored line spells exactly
	function automatic word_t match_line();
		string txt;
		bit    same;
		for (int w = WORD_LED_ON; w < WORD_NONE; w++) begin
			txt = word_text(word_t'(w));
			if (txt.len() == line_len) begin
				same = 1'b1;
				for (int j = 0; j < txt.len(); j++) begin
					if (line_buf[j] != txt[j])
						same = 1'b0;
				end
				if (same)
					return word_t'(w);
			end
		end
		return WORD_NONE;
	endfunction

	function automatic console_result_t echo_of(logic [7:0] ch, logic fin);
		console_result_t r;
		r = '0;
		r.is_echo = 1'b1;
		r.echo_byte = ch;
		r.last = fin;
		return r;
	endfunction

	// Update the line copy and queue the results one item causes
	task automatic edit_line(logic k, logic [7:0] b);
		console_result_t r;
		word_t           w;
		if (k) begin
			line_len = '0;
		end else if (b == lecm_pkg::CH_CR || b == lecm_pkg::CH_LF) begin
			if (line_len != 0) begin
				console_q.push_back(echo_of(lecm_pkg::CH_CR, 1'b0));
				console_q.push_back(echo_of(lecm_pkg::CH_LF, 1'b0));
				w = match_line();
				r = '0;
				r.last = 1'b1;
				case (w)
					WORD_LED_ON: begin
						r.led_write = 1'b1;
						r.red = lecm_pkg::LED_FULL;
						r.green = lecm_pkg::LED_FULL;
						r.blue = lecm_pkg::LED_FULL;
					end
					WORD_LED_OFF: r.led_write = 1'b1;
					WORD_RED: begin
						r.led_write = 1'b1;
						r.red = lecm_pkg::LED_FULL;
					end
					WORD_GREEN: begin
						r.led_write = 1'b1;
						r.green = lecm_pkg::LED_FULL;
					end
					WORD_BLUE: begin
						r.led_write = 1'b1;
						r.blue = lecm_pkg::LED_FULL;
					end
					default: r.unknown = 1'b1;
				endcase
				console_q.push_back(r);
				line_len = '0;
			end
		end else if (b == lecm_pkg::CH_BS || b == lecm_pkg::CH_DEL) begin
			if (line_len != 0) begin
				line_len = line_len - 1'b1;
				console_q.push_back(echo_of(lecm_pkg::CH_BS, 1'b0));
				console_q.push_back(echo_of(lecm_pkg::CH_SPACE, 1'b0));
				console_q.push_back(echo_of(lecm_pkg::CH_BS, 1'b1));
			end
		end else if (b >= lecm_pkg::CH_SPACE && b <= lecm_pkg::CH_TILDE) begin
			// drop the byte silently when the line is full
			if (line_len < LINE_CAPACITY - 1) begin
				line_buf[line_len] = b;
				line_len = line_len + 1'b1;
				console_q.push_back(echo_of(b, 1'b1));
			end
		end
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Compare results first, then predict the item accepted at the same edge
	always @(posedge clk or negedge arst_n) begin
		console_result_t want;
		if (!arst_n) begin
			line_len = '0;
			console_q.delete();
			pending = 0;
		end else begin
			if (result_valid && result_ready) begin
				if (console_q.size() == 0) begin
					$error("result accepted with no item pending");
					errors++;
				end else begin
					want = console_q.pop_front();
					check_field("is_echo", 8'(want.is_echo), 8'(is_echo));
					check_field("echo_byte", want.echo_byte, echo_byte);
					check_field("led_write", 8'(want.led_write), 8'(led_write));
					check_field("led_red", want.red, led_red);
					check_field("led_green", want.green, led_green);
					check_field("led_blue", want.blue, led_blue);
					check_field("unknown_command", 8'(want.unknown),
						8'(unknown_command));
					check_field("last", 8'(want.last), 8'(last));
				end
			end
			if (item_valid && item_ready)
				edit_line(kind, rx_byte);
			pending = console_q.size();
		end
	end

endmodule

// ===== bench/line_editor_command_matcher_tb.sv =====
// ----------------------------------------------------------------------------
// line_editor_command_matcher_tb
// Drives console bytes and overflow events into the line editor: a directed
// opening over the byte classes and empty-line cases, then random command
// lines, near misses, full lines and noise, under changing idle and stall
// patterns. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module line_editor_command_matcher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_CAPACITY  = 64;
	localparam int ITEM_TARGET    = 450;
	localparam int WATCHDOG_LIMIT = 5000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	logic       kind = 1'b0;
	logic [7:0] rx_byte = 8'd0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic       is_echo;
	logic [7:0] echo_byte;
	logic       led_write;
	logic [7:0] led_red;
	logic [7:0] led_green;
	logic [7:0] led_blue;
	logic       unknown_command;
	logic       last;
	int         errors;
	int         pending;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	line_editor_command_matcher #(.LINE_CAPACITY(LINE_CAPACITY)) u_dut (.*);

	line_editor_command_matcher_checker #(.LINE_CAPACITY(LINE_CAPACITY)) u_checker (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stall the result channel at the current rate
	always @(negedge clk)
		result_ready <= ($urandom_range(99) >= recv_stall_pct);

	// End the run when nothing has been accepted for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet_cycles <= 0;
			else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic string stim_word(int idx);
		case (idx)
			0:       return "LED_ON";
			1:       return "LED_OFF";
			2:       return "RED";
			3:       return "GREEN";
			default: return "BLUE";
		endcase
	endfunction

	function automatic logic [7:0] rand_printable();
		return 8'($urandom_range(lecm_pkg::CH_TILDE, lecm_pkg::CH_SPACE));
	endfunction

	// Present one item, hold it until accepted, then idle at random
	task automatic send_item(logic k, logic [7:0] b);
		item_valid <= 1'b1;
		kind <= k;
		rx_byte <= b;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		@(negedge clk);
		if (k || b == lecm_pkg::CH_CR || b == lecm_pkg::CH_LF ||
				b == lecm_pkg::CH_BS || b == lecm_pkg::CH_DEL ||
				(b >= lecm_pkg::CH_SPACE && b <= lecm_pkg::CH_TILDE))
			items_sent++;
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(1'b0, s[i]);
	endtask

	task automatic send_line_end();
		send_item(1'b0, $urandom_range(1) ? lecm_pkg::CH_CR : lecm_pkg::CH_LF);
	endtask

	initial begin
		string      w;
		int         choice;
		int         n;
		logic [7:0] ch;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty-line cases, ignored bytes, a match, an erase
		send_item(1'b1, 8'hFF);
		send_item(1'b0, lecm_pkg::CH_BS);
		send_item(1'b0, lecm_pkg::CH_CR);
		send_item(1'b0, lecm_pkg::CH_LF);
		send_item(1'b0, 8'd0);
		send_item(1'b0, 8'd31);
		send_item(1'b0, 8'd255);
		send_text("RED");
		send_item(1'b0, lecm_pkg::CH_CR);
		send_text("LED_ONX");
		send_item(1'b0, lecm_pkg::CH_DEL);
		send_item(1'b0, lecm_pkg::CH_LF);
		send_item(1'b0, lecm_pkg::CH_SPACE);
		send_item(1'b0, lecm_pkg::CH_TILDE);
		send_item(1'b1, lecm_pkg::CH_CR);
		send_item(1'b0, lecm_pkg::CH_CR);

		// Random: mostly command lines, with near misses, full lines and noise
		while (items_sent < ITEM_TARGET) begin
			case ((items_sent / 60) % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 86;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 86;
				end
				default: begin
					send_idle_pct = 35;
					recv_stall_pct = 35;
				end
			endcase
			choice = $urandom_range(99);
			w = stim_word($urandom_range(4));
			if (choice < 45) begin
				// well-formed command, sometimes with a typo erased first
				if ($urandom_range(3) == 0) begin
					send_item(1'b0, rand_printable());
					send_item(1'b0, $urandom_range(1) ? lecm_pkg::CH_BS : lecm_pkg::CH_DEL);
				end
				send_text(w);
				send_line_end();
			end else if (choice < 60) begin
				// near miss: short, long or one character changed
				case ($urandom_range(2))
					0: send_text(w.substr(0, w.len() - 2));
					1: begin
						send_text(w);
						send_item(1'b0, rand_printable());
					end
					default: begin
						w[$urandom_range(w.len() - 1)] = rand_printable();
						send_text(w);
					end
				endcase
				send_line_end();
			end else if (choice < 75) begin
				// random printable line, erase now and then
				n = $urandom_range(8, 1);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(5) == 0)
						send_item(1'b0, $urandom_range(1) ? lecm_pkg::CH_BS : lecm_pkg::CH_DEL);
					else
						send_item(1'b0, rand_printable());
				end
				send_line_end();
			end else if (choice < 98) begin
				// single noise item, biased toward control codes
				case ($urandom_range(5))
					0: ch = lecm_pkg::CH_CR;
					1: ch = lecm_pkg::CH_LF;
					2: ch = $urandom_range(1) ? lecm_pkg::CH_BS : lecm_pkg::CH_DEL;
					default: ch = 8'($urandom_range(255));
				endcase
				send_item($urandom_range(9) == 0, ch);
			end else begin
				// fill the line past capacity, trim it, then end it
				for (int i = 0; i < LINE_CAPACITY + 2; i++)
					send_item(1'b0, rand_printable());
				n = $urandom_range(3, 1);
				for (int i = 0; i < n; i++)
					send_item(1'b0, lecm_pkg::CH_BS);
				send_item(1'b0, rand_printable());
				send_line_end();
			end
		end

		// Drain and let the block settle
		item_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
